// ===== design/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque: operation and status
// codes, and the shift command that is broadcast to the row of cells.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam logic [OP_W-1:0] OP_ADD_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_BACK  = 3'd3;
  localparam logic [OP_W-1:0] OP_REM_AT    = 3'd4;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_IGNORED = 2'd2;

  // Command seen by every cell in the cycle an item transfers.
  typedef struct packed {
    logic front_ins;  // every cell takes its left neighbor
    logic back_ins;   // the cell at the current count takes the new value
    logic close;      // cells at and above the gap take their right neighbor
  } shift_cmd_t;

endpackage

// ===== design/bdq_cell.sv =====
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the deque row. Holds a single entry and either keeps
// it, takes the neighbor on its left or right, or loads the new value.
// ----------------------------------------------------------------------------
module bdq_cell import bdq_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                     clk,
  input  shift_cmd_t               cmd,
  input  logic        [CW-1:0]     count,
  input  logic        [CW-1:0]     gap,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  output logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] tap
);

  localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
  localparam logic [CW-1:0] MY_LAST = CW'(IDX + 1);

  logic signed [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    if (cmd.front_ins) begin
      data_next = left;
    end else if (cmd.back_ins && (count == MY_IDX)) begin
      data_next = value;
    end else if (cmd.close && (MY_IDX >= gap)) begin
      data_next = right;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Only the cell holding the back entry drives its tap.
  assign tap = (count == MY_LAST) ? data : '0;

endmodule

// ===== design/bounded_deque_with_delete_at_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_delete_at_unit
// Deque of up to DEPTH signed 32-bit entries with delete at position.
// ----------------------------------------------------------------------------
// The entries sit in a row of DEPTH shifting cells, front at cell 0. An
// operation transfers in, and every cell updates at that same clock edge
// (insert at front shifts the row up, remove at a position shifts the upper
// part down). When the result register is free or transferring out, the front
// and back values are read from the updated row (the back through a one-hot
// select keyed by the count) into the result register. A new operation is
// taken once the previous result is in the result register, so no operation
// is taken while an earlier one still waits in the row; while a result waits
// on a stalled output, the next operation is held in the row and its result
// loads in the cycle the waiting one transfers out.
// Adds to a full deque report status 1; removes from an empty deque, a
// position past the end or an unused operation code report status 2.
module bounded_deque_with_delete_at_unit import bdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic        [OP_W-1:0]   operation,
  input  logic signed [DATA_W-1:0] value,
  input  logic        [POS_W-1:0]  position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic        [STAT_W-1:0] status,
  output logic        [COUNT_W-1:0] count,
  output logic signed [DATA_W-1:0] front_value,
  output logic signed [DATA_W-1:0] back_value
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [CW-1:0] entry_count, entry_count_next;
  logic          pend;
  status_t       status_q, status_next;
  shift_cmd_t    cmd;
  logic [CW-1:0] gap;
  logic          in_fire;
  logic          load_out;
  logic          full, empty, pos_ok;
  logic [XW-1:0] pos_x, cnt_x;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic signed [DATA_W-1:0] cell_tap  [DEPTH];
  logic signed [DATA_W-1:0] back_sel;
  logic [31:0]              count_ext;

  assign in_ready = !pend;
  assign in_fire  = in_valid && in_ready;
  assign load_out = pend && (!out_valid || out_ready);

  assign full  = (entry_count == FULL_CNT);
  assign empty = (entry_count == '0);
  assign pos_x = XW'(position);
  assign cnt_x = XW'(entry_count);
  assign pos_ok = (pos_x < cnt_x);

  always_comb begin
    cmd              = '0;
    gap              = '0;
    status_next      = ST_DONE;
    entry_count_next = entry_count;
    case (operation)
      OP_ADD_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.front_ins    = in_fire;
          entry_count_next = entry_count + 1'b1;
        end
      end
      OP_ADD_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.back_ins     = in_fire;
          entry_count_next = entry_count + 1'b1;
        end
      end
      OP_REM_FRONT: begin
        if (empty) begin
          status_next = ST_IGNORED;
        end else begin
          cmd.close        = in_fire;
          entry_count_next = entry_count - 1'b1;
        end
      end
      OP_REM_BACK: begin
        if (empty) begin
          status_next = ST_IGNORED;
        end else begin
          entry_count_next = entry_count - 1'b1;
        end
      end
      OP_REM_AT: begin
        if (!pos_ok) begin
          status_next = ST_IGNORED;
        end else begin
          cmd.close        = in_fire;
          gap              = CW'(pos_x);
          entry_count_next = entry_count - 1'b1;
        end
      end
      default: begin
        status_next = ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      pend        <= 1'b0;
    end else begin
      if (in_fire) begin
        entry_count <= entry_count_next;
        pend        <= 1'b1;
      end else if (load_out) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_q <= status_next;
    end
  end

  // Row of cells; cell 0 takes the new value when the row shifts up.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_in, right_in;
    if (i == 0) begin : g_first
      assign left_in = value;
    end else begin : g_mid
      assign left_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = cell_data[i];
    end else begin : g_inner
      assign right_in = cell_data[i+1];
    end

    bdq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .count (entry_count),
      .gap   (gap),
      .value (value),
      .left  (left_in),
      .right (right_in),
      .data  (cell_data[i]),
      .tap   (cell_tap[i])
    );
  end

  always_comb begin
    back_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_sel = back_sel | cell_tap[i];
    end
  end

  assign count_ext = 32'(entry_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= status_q;
      count       <= count_ext[COUNT_W-1:0];
      front_value <= empty ? '0 : cell_data[0];
      back_value  <= back_sel;
    end
  end

endmodule

// ===== design/bdq_checker.sv =====
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on the deque results, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker import bdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic        [OP_W-1:0]    operation,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic        [STAT_W-1:0]  status,
  input logic        [COUNT_W-1:0] count,
  input logic signed [DATA_W-1:0]  front_value,
  input logic signed [DATA_W-1:0]  back_value
);

  localparam logic [31:0] DEPTH_W = 32'(DEPTH);

  // A waiting result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count)
      && $stable(front_value) && $stable(back_value))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (count == '0) |-> (front_value == '0) && (back_value == '0))
    else $error("empty deque shows nonzero front or back");

  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (count == COUNT_W'(1)) |-> (front_value == back_value))
    else $error("single entry: front and back differ");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (32'(count) == (DEPTH_W & 32'h1F)))
    else $error("full status with count below depth");

  // The shown result belongs to the sampled earlier transfer only when the
  // output register was free at the edge between that transfer and the load.
  a_ignored_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_IGNORED) && $past(in_valid && in_ready, 2)
      && $past(!out_valid || out_ready)
      && (($past(operation, 2) == OP_REM_FRONT) || ($past(operation, 2) == OP_REM_BACK))
      |-> (count == '0))
    else $error("front/back remove ignored on nonempty deque");

endmodule

bind bounded_deque_with_delete_at_unit bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (.*);
